// ===== design/rlm_pkg.sv =====
// ----------------------------------------------------------------------------
// rlm_pkg: shared constants for the RMS level meter
// Field widths, fixed-point limits and sizing of the divide and root steps.
// ----------------------------------------------------------------------------
package rlm_pkg;

    localparam int DEF_MAX_RUN = 4096;

    localparam int SAMPLE_W   = 16;
    localparam int SQ_W       = 31;
    localparam int MEAN_W     = 31;
    localparam int RAD_W      = 36;
    localparam int ROOT_W     = 18;
    localparam int SQRT_STEPS = RAD_W / 2;
    localparam int LEVEL_W    = 17;
    localparam int TDATA_W    = 24;

    localparam logic [LEVEL_W-1:0] FULL_SCALE = 17'h10000;

endpackage

// ===== design/rlm_accum.sv =====
// ----------------------------------------------------------------------------
// rlm_accum: square-accumulate stage
// Squares each sample, sums and counts up to MAX_RUN samples per run and
// flags ignored samples. Presents the run totals including the current beat, unless the run is full.
// ----------------------------------------------------------------------------
module rlm_accum
    import rlm_pkg::*;
#(
    parameter int MAX_RUN = DEF_MAX_RUN,
    parameter int CNT_W   = $clog2(MAX_RUN + 1),
    parameter int SUM_W   = SQ_W + CNT_W
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       take,
    input  logic                       last,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic [SUM_W-1:0]           run_sum,
    output logic [CNT_W-1:0]           run_count,
    output logic                       run_ovf
);

    logic [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0] count_reg;
    logic             ovf_reg;
    logic signed [2*SAMPLE_W-1:0] sq_full;
    logic [SQ_W-1:0]  sq;
    logic             full;

    assign sq_full = sample * sample;
    assign sq      = sq_full[SQ_W-1:0];
    assign full    = (count_reg == CNT_W'(MAX_RUN));

    always_comb begin
        if (full) begin
            run_sum   = sum_reg;
            run_count = count_reg;
            run_ovf   = 1'b1;
        end else begin
            run_sum   = sum_reg + SUM_W'(sq);
            run_count = count_reg + CNT_W'(1);
            run_ovf   = ovf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else if (take) begin
            if (last) begin
                sum_reg   <= '0;
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end else begin
                sum_reg   <= run_sum;
                count_reg <= run_count;
                ovf_reg   <= run_ovf;
            end
        end
    end

endmodule

// ===== design/rlm_divsqrt.sv =====
// ----------------------------------------------------------------------------
// rlm_divsqrt: iterative mean and root unit
// One shared subtract/compare unit runs a restoring divide of the sum by the
// count, one bit a cycle, then a restoring square root of 36 times the mean.
// ----------------------------------------------------------------------------
module rlm_divsqrt
    import rlm_pkg::*;
#(
    parameter int MAX_RUN = DEF_MAX_RUN,
    parameter int CNT_W   = $clog2(MAX_RUN + 1),
    parameter int SUM_W   = SQ_W + CNT_W
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [SUM_W-1:0]   run_sum,
    input  logic [CNT_W-1:0]   run_count,
    input  logic               run_ovf,
    input  logic               res_take,
    output logic               res_valid,
    output logic               busy,
    output logic [LEVEL_W-1:0] level,
    output logic               truncated
);

    localparam int SUB_W  = (CNT_W + 1 > ROOT_W + 2) ? CNT_W + 1 : ROOT_W + 2;
    localparam int STEP_W = $clog2(SUM_W);

    typedef enum logic [2:0] {ST_IDLE, ST_DIV, ST_SCALE, ST_SQRT, ST_DONE} state_t;

    state_t            state_reg;
    logic [STEP_W-1:0] step_reg;
    logic [SUM_W-1:0]  dvd_reg;
    logic [CNT_W-1:0]  dvs_reg;
    logic [SUB_W-1:0]  rem_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [ROOT_W-1:0] root_reg;
    logic              zdiv_reg;
    logic              ovf_reg;

    logic [SUB_W-1:0]  op_a;
    logic [SUB_W-1:0]  op_b;
    logic [SUB_W:0]    diff;
    logic              ge;
    logic [MEAN_W-1:0] mean;

    always_comb begin
        if (state_reg == ST_SQRT) begin
            op_a = {rem_reg[SUB_W-3:0], rad_reg[RAD_W-1 -: 2]};
            op_b = SUB_W'({root_reg, 2'b01});
        end else begin
            op_a = {rem_reg[SUB_W-2:0], dvd_reg[SUM_W-1]};
            op_b = SUB_W'(dvs_reg);
        end
    end

    assign diff = {1'b0, op_a} - {1'b0, op_b};
    assign ge   = !diff[SUB_W];
    assign mean = zdiv_reg ? '0 : dvd_reg[MEAN_W-1:0];

    assign res_valid = (state_reg == ST_DONE);
    assign busy      = (state_reg != ST_IDLE);
    assign level     = (root_reg > ROOT_W'(FULL_SCALE)) ? FULL_SCALE
                                                        : root_reg[LEVEL_W-1:0];
    assign truncated = ovf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        dvd_reg   <= run_sum;
                        dvs_reg   <= run_count;
                        zdiv_reg  <= (run_count == '0);
                        ovf_reg   <= run_ovf;
                        rem_reg   <= '0;
                        step_reg  <= STEP_W'(SUM_W - 1);
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    rem_reg  <= ge ? diff[SUB_W-1:0] : op_a;
                    dvd_reg  <= {dvd_reg[SUM_W-2:0], ge};
                    step_reg <= step_reg - STEP_W'(1);
                    if (step_reg == '0) begin
                        state_reg <= ST_SCALE;
                    end
                end
                ST_SCALE: begin
                    rad_reg   <= (RAD_W'(mean) << 5) + (RAD_W'(mean) << 2);
                    rem_reg   <= '0;
                    root_reg  <= '0;
                    step_reg  <= STEP_W'(SQRT_STEPS - 1);
                    state_reg <= ST_SQRT;
                end
                ST_SQRT: begin
                    rem_reg  <= ge ? diff[SUB_W-1:0] : op_a;
                    root_reg <= {root_reg[ROOT_W-2:0], ge};
                    rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
                    step_reg <= step_reg - STEP_W'(1);
                    if (step_reg == '0) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (res_take) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== design/rms_level_meter.sv =====
// ----------------------------------------------------------------------------
// rms_level_meter: RMS level of runs of signed 16-bit PCM samples
// Emits min(1, 3*rms) in 1.16 unsigned fixed point once per run.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one sample per beat in s_tdata, s_tlast marks the last sample of
//   a run. Non-last samples take one cycle each and may come back to back.
//   Samples past MAX_RUN in a run are dropped and set the truncated flag.
//   m_axis: one beat per run, level in m_tdata[16:0] (65536 = full scale),
//   truncated in m_tuser.
//   After the last beat of a run the result is computed by the bit-serial
//   divide (SUM_W steps) and root (18 steps) on one subtractor; s_tready
//   is low meanwhile. A waiting result sits in the output register, so
//   input is taken again while m_tready is low; a second result waits in
//   the unit.
//   Reset clears the run totals, the sequencer and m_tvalid.
// ----------------------------------------------------------------------------
module rms_level_meter
    import rlm_pkg::*;
#(
    parameter int MAX_RUN = DEF_MAX_RUN
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [SAMPLE_W-1:0] s_tdata,   // [15:0] sample
    input  logic               s_tlast,   // last_in_run
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [16:0] level, [23:17] zero
    output logic               m_tuser    // [0] truncated
);

    localparam int CNT_W = $clog2(MAX_RUN + 1);
    localparam int SUM_W = SQ_W + CNT_W;

    logic               s_take;
    logic [SUM_W-1:0]   run_sum;
    logic [CNT_W-1:0]   run_count;
    logic               run_ovf;
    logic               res_valid;
    logic               res_take;
    logic               busy;
    logic [LEVEL_W-1:0] level;
    logic               truncated;

    logic               m_tvalid_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic               trunc_reg;

    assign s_tready = !busy;
    assign s_take   = s_tvalid && s_tready;
    assign res_take = res_valid && (!m_tvalid_reg || m_tready);

    rlm_accum #(
        .MAX_RUN (MAX_RUN),
        .CNT_W   (CNT_W),
        .SUM_W   (SUM_W)
    ) u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (s_take),
        .last      (s_tlast),
        .sample    ($signed(s_tdata)),
        .run_sum   (run_sum),
        .run_count (run_count),
        .run_ovf   (run_ovf)
    );

    rlm_divsqrt #(
        .MAX_RUN (MAX_RUN),
        .CNT_W   (CNT_W),
        .SUM_W   (SUM_W)
    ) u_divsqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_take && s_tlast),
        .run_sum   (run_sum),
        .run_count (run_count),
        .run_ovf   (run_ovf),
        .res_take  (res_take),
        .res_valid (res_valid),
        .busy      (busy),
        .level     (level),
        .truncated (truncated)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            if (res_take) begin
                m_tvalid_reg <= 1'b1;
                level_reg    <= level;
                trunc_reg    <= truncated;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_W'(level_reg);
    assign m_tuser  = trunc_reg;

    a_last_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input taken right after the last beat of a run");

    a_level_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[16]) |-> (m_tdata[15:0] == 16'h0000))
        else $error("level above full scale");

    a_res_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && !res_take) |=> (res_valid && $stable(level)))
        else $error("pending result lost or changed");

endmodule
